[src/pfyg_pkg.sv]
// Shared types, constants and helpers for the path-following yaw guidance block.
// Used by the CORDIC unit, the shift-subtract unit and the top level.
package pfyg_pkg;

   localparam int CORDIC_STEPS_DEF  = 16;
   localparam int INTEGRAL_BITS_DEF = 48;

   // datapath widths inside the CORDIC unit
   localparam int CW = 36;
   localparam int ZW = 34;

   localparam int ATAN_IDX_W = 5;

   localparam int DIV_STEPS  = 30;
   localparam int ROOT_STEPS = 31;

   localparam logic [23:0] GAIN_Q24 = 24'd10187982;
   localparam logic [16:0] YAW_SCALE = 17'd46080;

   typedef struct packed {
      logic start;
      logic vectoring;
   } cordic_ctl_type;

   typedef struct packed {
      logic start;
      logic root_mode;
   } shiftsub_ctl_type;

   // arctan(2^-i) with 2^32 per full circle
   function automatic logic [31:0] atan_angle(input logic [ATAN_IDX_W-1:0] idx);
      logic [31:0] a;
      unique case (idx)
         5'd0:    a = 32'h20000000;
         5'd1:    a = 32'h12E4051D;
         5'd2:    a = 32'h09FB385B;
         5'd3:    a = 32'h051111D4;
         5'd4:    a = 32'h028B0D43;
         5'd5:    a = 32'h0145D7E1;
         5'd6:    a = 32'h00A2F61E;
         5'd7:    a = 32'h00517C55;
         5'd8:    a = 32'h0028BE53;
         5'd9:    a = 32'h00145F2E;
         5'd10:   a = 32'h000A2F98;
         5'd11:   a = 32'h000517CC;
         5'd12:   a = 32'h00028BE6;
         5'd13:   a = 32'h000145F3;
         5'd14:   a = 32'h0000A2F9;
         5'd15:   a = 32'h0000517C;
         5'd16:   a = 32'h000028BE;
         5'd17:   a = 32'h0000145F;
         5'd18:   a = 32'h00000A2F;
         5'd19:   a = 32'h00000517;
         5'd20:   a = 32'h0000028B;
         5'd21:   a = 32'h00000145;
         5'd22:   a = 32'h000000A2;
         5'd23:   a = 32'h00000051;
         default: a = 32'h00000000;
      endcase
      return a;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sh000000007FFFFFFF) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -64'sh0000000080000000) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

[src/pfyg_cordic.sv]
// Iterative CORDIC unit, one micro-rotation per cycle, rotation or vectoring mode.
// Depends on pfyg_pkg for widths, the control struct and the arctan table.
module pfyg_cordic
   import pfyg_pkg::*;
#(
   parameter int STEPS = CORDIC_STEPS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cordic_ctl_type       ctl,
   input  logic signed [CW-1:0] x_start,
   input  logic signed [CW-1:0] y_start,
   input  logic signed [ZW-1:0] z_start,
   output logic signed [CW-1:0] x_out,
   output logic signed [CW-1:0] y_out,
   output logic signed [ZW-1:0] z_out,
   output logic                 done
);

   localparam int NW = (STEPS > 1) ? $clog2(STEPS) : 1;

   logic signed [CW-1:0] x_ff, y_ff, x_in, y_in;
   logic signed [ZW-1:0] z_ff, z_in;
   logic [NW-1:0]        cnt_ff;
   logic                 busy_ff, done_ff, vec_ff;
   logic signed [CW-1:0] xs, ys;
   logic signed [ZW-1:0] step_ang;
   logic                 pos;

   assign xs       = x_ff >>> cnt_ff;
   assign ys       = y_ff >>> cnt_ff;
   assign step_ang = $signed({{(ZW-32){1'b0}}, atan_angle(ATAN_IDX_W'(cnt_ff))});
   // vectoring drives y to zero, rotation drives z to zero
   assign pos      = vec_ff ? y_ff[CW-1] : !z_ff[ZW-1];

   always_comb begin
      if (pos) begin
         x_in = x_ff - ys;
         y_in = y_ff + xs;
         z_in = z_ff - step_ang;
      end else begin
         x_in = x_ff + ys;
         y_in = y_ff - xs;
         z_in = z_ff + step_ang;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         vec_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            vec_ff  <= ctl.vectoring;
         end else if (busy_ff) begin
            if (cnt_ff == NW'(STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         x_ff <= x_start;
         y_ff <= y_start;
         z_ff <= z_start;
      end else if (busy_ff) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;
   assign done  = done_ff;

endmodule

[src/pfyg_shiftsub.sv]
// Shared compare-subtract unit: restoring division or integer square root, one digit a cycle.
// Depends on pfyg_pkg for the control struct and step counts.
module pfyg_shiftsub
   import pfyg_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  shiftsub_ctl_type ctl,
   input  logic [15:0]      divisor,
   input  logic [15:0]      rem_start,
   input  logic [61:0]      opnd_start,
   output logic [30:0]      result,
   output logic             done
);

   logic [33:0] rem_ff, rem_in;
   logic [30:0] acc_ff;
   logic [61:0] opnd_ff;
   logic [15:0] dvs_ff;
   logic [4:0]  cnt_ff;
   logic        busy_ff, done_ff, root_ff;
   logic [33:0] a_op, b_op;
   logic [34:0] diff;
   logic        ge, last;

   always_comb begin
      if (root_ff) begin
         a_op = {rem_ff[31:0], opnd_ff[61:60]};
         b_op = {1'b0, acc_ff, 2'b01};
      end else begin
         a_op = {17'd0, rem_ff[15:0], opnd_ff[61]};
         b_op = {18'd0, dvs_ff};
      end
      diff   = {1'b0, a_op} - {1'b0, b_op};
      ge     = !diff[34];
      rem_in = ge ? diff[33:0] : a_op;
      last   = root_ff ? (cnt_ff == 5'(ROOT_STEPS - 1)) : (cnt_ff == 5'(DIV_STEPS - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         root_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            root_ff <= ctl.root_mode;
         end else if (busy_ff) begin
            if (last) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         rem_ff  <= ctl.root_mode ? 34'd0 : {18'd0, rem_start};
         acc_ff  <= '0;
         opnd_ff <= opnd_start;
         dvs_ff  <= divisor;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         acc_ff  <= {acc_ff[29:0], ge};
         opnd_ff <= root_ff ? {opnd_ff[59:0], 2'b00} : {opnd_ff[60:0], 1'b0};
      end
   end

   assign result = acc_ff;
   assign done   = done_ff;

endmodule

[src/path_following_yaw_guidance.sv]
// Path-following yaw guidance, PI cross-track law. One beat on req_ in gives one beat on
// rsp_. Each item runs the CORDIC unit (rotation, then vectoring for the arcsine) and the
// shift-subtract unit (30-step division, 31-step square root); the division is skipped when
// the numerator is zero or the correction is clamped. req_tready is high only between
// items; a finished result waits in the output register while the next beat is taken.
// Gains are written through csr_; the user must write them only while the block is idle,
// which the block itself does not enforce.
module path_following_yaw_guidance
   import pfyg_pkg::*;
#(
   parameter int CORDIC_STEPS  = CORDIC_STEPS_DEF,
   parameter int INTEGRAL_BITS = INTEGRAL_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // path_x, path_y, path_heading, path_speed, current_speed, tan_len,
   // vehicle_x, vehicle_y, vehicle_surge
   input  logic [207:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // desired_yaw, desired_surge, lateral_err, along_err, zero pad
   output logic [119:0] rsp_tdata,
   input  logic         csr_we,
   input  logic         csr_addr,
   input  logic [15:0]  csr_wdata
);

   localparam int IB = INTEGRAL_BITS;

   localparam logic CSR_CROSS_GAIN = 1'b0;
   localparam logic CSR_INT_GAIN   = 1'b1;

   localparam logic [4:0] ST_IDLE  = 5'd0;
   localparam logic [4:0] ST_ROT   = 5'd1;
   localparam logic [4:0] ST_SCX   = 5'd2;
   localparam logic [4:0] ST_SCY   = 5'd3;
   localparam logic [4:0] ST_INTEG = 5'd4;
   localparam logic [4:0] ST_PLO   = 5'd5;
   localparam logic [4:0] ST_PHI   = 5'd6;
   localparam logic [4:0] ST_NUM   = 5'd7;
   localparam logic [4:0] ST_DSET  = 5'd8;
   localparam logic [4:0] ST_DIV   = 5'd9;
   localparam logic [4:0] ST_SQ    = 5'd10;
   localparam logic [4:0] ST_SQW   = 5'd11;
   localparam logic [4:0] ST_VEC   = 5'd12;
   localparam logic [4:0] ST_YAW   = 5'd13;
   localparam logic [4:0] ST_OUT   = 5'd14;

   logic [4:0] state_ff, state_in;

   logic [15:0] k1_ff, k2_ff;

   // input fields
   logic signed [31:0] f_px, f_py, f_vx, f_vy;
   logic        [15:0] f_head, f_tn;
   logic signed [15:0] f_vd, f_vc, f_surge;

   assign f_px    = req_tdata[31:0];
   assign f_py    = req_tdata[63:32];
   assign f_head  = req_tdata[79:64];
   assign f_vd    = req_tdata[95:80];
   assign f_vc    = req_tdata[111:96];
   assign f_tn    = req_tdata[127:112];
   assign f_vx    = req_tdata[159:128];
   assign f_vy    = req_tdata[191:160];
   assign f_surge = req_tdata[207:192];

   logic req_fire;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // payload registers
   logic signed [15:0]   hs_ff, surge_ff;
   logic signed [31:0]   dsurge_ff, ex_ff, ey_ff;
   logic signed [IB-1:0] integ_ff;
   logic signed [48:0]   t1_ff;
   logic        [40:0]   plo_ff;
   logic        [39:0]   phi_ff;
   logic signed [51:0]   num_ff;
   logic        [30:0]   mag_ff;
   logic                 cneg_ff;
   logic signed [16:0]   yaw_ff;
   logic                 rsp_valid_ff;
   logic        [119:0]  rsp_data_ff;

   // rotator set-up from the incoming beat
   logic signed [32:0]   ex_raw;
   logic        [15:0]   hn;
   logic                 flip;
   logic signed [CW-1:0] rot_x0, rot_y0;
   logic signed [ZW-1:0] rot_z0;
   logic signed [16:0]   vsum;
   logic signed [33:0]   surge_prod;

   always_comb begin
      ex_raw     = 33'(f_vx) - 33'(f_px);
      hn         = 16'd0 - f_head;
      flip       = hn[15] ^ hn[14];
      rot_x0     = flip ? -CW'(ex_raw) : CW'(ex_raw);
      rot_y0     = flip ? -CW'(33'(f_vy) - 33'(f_py)) : CW'(33'(f_vy) - 33'(f_py));
      rot_z0     = ZW'($signed({hn[15] ^ flip, hn[14:0], 16'd0}));
      vsum       = 17'(f_vd) + 17'(f_vc);
      surge_prod = vsum * $signed({1'b0, f_tn});
   end

   // shared CORDIC
   cordic_ctl_type       cor_ctl;
   logic signed [CW-1:0] cor_x0, cor_y0, cor_x, cor_y;
   logic signed [ZW-1:0] cor_z0, cor_z;
   logic                 cor_done;
   logic signed [CW-1:0] c_vec;

   assign c_vec = cneg_ff ? -CW'({1'b0, mag_ff}) : CW'({1'b0, mag_ff});

   // shift-subtract unit
   shiftsub_ctl_type ss_ctl;
   logic [15:0]      ss_dvs, ss_rem0;
   logic [61:0]      ss_opnd0;
   logic [30:0]      ss_res;
   logic             ss_done;

   // gain scaling of the rotator outputs
   logic signed [CW-1:0] scale_in;
   logic signed [60:0]   scale_prod;
   logic signed [36:0]   scale_sh;
   logic signed [31:0]   scale_sat;

   assign scale_in   = (state_ff == ST_SCX) ? cor_x : cor_y;
   assign scale_prod = scale_in * $signed({1'b0, GAIN_Q24});
   assign scale_sh   = 37'((scale_prod + 61'sd8388608) >>> 24);
   assign scale_sat  = sat32(64'(scale_sh));

   // integral and numerator
   logic signed [IB:0]   integ_sum;
   logic signed [IB-1:0] integ_next;
   logic        [IB-1:0] mi_abs;
   logic        [63:0]   mi_wide;
   logic        [48:0]   mi_c;
   logic        [65:0]   psum;
   logic        [50:0]   t2mag;
   logic signed [51:0]   t2, num_next;
   logic        [51:0]   an;
   logic        [15:0]   as_mag;
   logic                 clamp_one;

   always_comb begin
      integ_sum = (IB+1)'(integ_ff) + (IB+1)'(ey_ff);
      if (integ_sum[IB] != integ_sum[IB-1]) begin
         integ_next = integ_sum[IB] ? {1'b1, {(IB-1){1'b0}}} : {1'b0, {(IB-1){1'b1}}};
      end else begin
         integ_next = integ_sum[IB-1:0];
      end
      mi_abs   = integ_ff[IB-1] ? (IB'(0) - integ_ff) : integ_ff;
      mi_wide  = 64'(mi_abs);
      mi_c     = (mi_wide > (64'd1 << 48)) ? (49'd1 << 48) : mi_wide[48:0];
      psum     = {1'b0, phi_ff, 25'd0} + 66'(plo_ff);
      t2mag    = (psum > (66'd1 << 50)) ? (51'd1 << 50) : psum[50:0];
      t2       = integ_ff[IB-1] ? -$signed({1'b0, t2mag}) : $signed({1'b0, t2mag});
      num_next = 52'(t1_ff) + t2;
      an       = num_ff[51] ? 52'(-num_ff) : 52'(num_ff);
      as_mag   = surge_ff[15] ? 16'(-surge_ff) : 16'(surge_ff);
      clamp_one = (an >= {20'd0, as_mag, 16'd0});
   end

   // arcsine argument
   logic [61:0] mag_sq;
   assign mag_sq = 62'(mag_ff) * 62'(mag_ff);

   // final yaw
   logic signed [34:0] yaw_sum;
   logic signed [51:0] yaw_prod;
   assign yaw_sum  = 35'($signed({hs_ff, 16'd0})) + 35'(cor_z);
   assign yaw_prod = yaw_sum * $signed(YAW_SCALE);

   logic out_free;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // sequencer
   always_comb begin
      state_in         = state_ff;
      cor_ctl.start    = 1'b0;
      cor_ctl.vectoring = 1'b0;
      cor_x0           = rot_x0;
      cor_y0           = rot_y0;
      cor_z0           = rot_z0;
      ss_ctl.start     = 1'b0;
      ss_ctl.root_mode = 1'b0;
      ss_dvs           = as_mag;
      ss_rem0          = an[31:16];
      ss_opnd0         = {an[15:0], 46'd0};
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cor_ctl.start = 1'b1;
               state_in      = ST_ROT;
            end
         end
         ST_ROT:   if (cor_done) state_in = ST_SCX;
         ST_SCX:   state_in = ST_SCY;
         ST_SCY:   state_in = ST_INTEG;
         ST_INTEG: state_in = ST_PLO;
         ST_PLO:   state_in = ST_PHI;
         ST_PHI:   state_in = ST_NUM;
         ST_NUM:   state_in = ST_DSET;
         ST_DSET: begin
            if (num_ff == '0 || clamp_one) begin
               state_in = ST_SQ;
            end else begin
               ss_ctl.start = 1'b1;
               state_in     = ST_DIV;
            end
         end
         ST_DIV:   if (ss_done) state_in = ST_SQ;
         ST_SQ: begin
            ss_ctl.start     = 1'b1;
            ss_ctl.root_mode = 1'b1;
            ss_opnd0         = (62'd1 << 60) - mag_sq;
            state_in         = ST_SQW;
         end
         ST_SQW: begin
            cor_x0 = CW'({1'b0, ss_res});
            cor_y0 = c_vec;
            cor_z0 = '0;
            if (ss_done) begin
               cor_ctl.start     = 1'b1;
               cor_ctl.vectoring = 1'b1;
               state_in          = ST_VEC;
            end
         end
         ST_VEC:   if (cor_done) state_in = ST_YAW;
         ST_YAW:   state_in = ST_OUT;
         ST_OUT:   if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k1_ff        <= '0;
         k2_ff        <= '0;
         integ_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_addr)
               CSR_CROSS_GAIN: k1_ff <= csr_wdata;
               CSR_INT_GAIN:   k2_ff <= csr_wdata;
               default:        k1_ff <= k1_ff;
            endcase
         end
         if (state_ff == ST_INTEG) integ_ff <= integ_next;
         if (state_ff == ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         hs_ff     <= f_head;
         surge_ff  <= f_surge;
         dsurge_ff <= sat32(64'(surge_prod));
      end
      if (state_ff == ST_SCX) ex_ff <= scale_sat;
      if (state_ff == ST_SCY) ey_ff <= scale_sat;
      if (state_ff == ST_INTEG) t1_ff <= $signed({1'b0, k1_ff}) * ey_ff;
      if (state_ff == ST_PLO) plo_ff <= k2_ff * mi_c[24:0];
      if (state_ff == ST_PHI) phi_ff <= k2_ff * mi_c[48:25];
      if (state_ff == ST_NUM) num_ff <= num_next;
      if (state_ff == ST_DSET) begin
         cneg_ff <= !(num_ff[51] != surge_ff[15]);
         if (num_ff == '0) begin
            mag_ff <= '0;
         end else if (clamp_one) begin
            mag_ff <= 31'd1 << 30;
         end
      end
      if (state_ff == ST_DIV && ss_done) mag_ff <= ss_res;
      if (state_ff == ST_YAW) yaw_ff <= 17'((yaw_prod + 52'sd2147483648) >>> 32);
      if (state_ff == ST_OUT && out_free) begin
         rsp_data_ff <= {7'd0, ex_ff, ey_ff, dsurge_ff, yaw_ff};
      end
   end

   pfyg_cordic #(
      .STEPS(CORDIC_STEPS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .ctl     (cor_ctl),
      .x_start (cor_x0),
      .y_start (cor_y0),
      .z_start (cor_z0),
      .x_out   (cor_x),
      .y_out   (cor_y),
      .z_out   (cor_z),
      .done    (cor_done)
   );

   pfyg_shiftsub u_shiftsub (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ss_ctl),
      .divisor    (ss_dvs),
      .rem_start  (ss_rem0),
      .opnd_start (ss_opnd0),
      .result     (ss_res),
      .done       (ss_done)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTH
   a_cordic_done_owner: assert property (@(posedge clock) disable iff (reset)
      cor_done |-> (state_ff == ST_ROT || state_ff == ST_VEC))
      else $error("cordic finished outside a cordic wait");

   a_shiftsub_done_owner: assert property (@(posedge clock) disable iff (reset)
      ss_done |-> (state_ff == ST_DIV || state_ff == ST_SQW))
      else $error("shift-subtract unit finished outside a wait");

   a_mag_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQ) |-> (mag_ff <= (31'd1 << 30)))
      else $error("correction magnitude above one");

   a_integ_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_INTEG) |=> $stable(integ_ff))
      else $error("integral moved outside its update step");
`endif

endmodule

[tb/path_following_yaw_guidance_tb.sv]
// Self-checking testbench for the path-following yaw guidance block.
// Drives control ticks on req_, predicts each rsp_ beat with an in-bench model of the
// fixed-point guidance law and compares field by field. Needs pfyg_pkg and the top level.
module path_following_yaw_guidance_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pfyg_pkg::*;

   localparam int STEPS     = 16;
   localparam int INTEG_W   = 48;
   localparam int WDOG_MAX  = 20000;
   localparam logic CSR_XTRACK_GAIN = 1'b0;
   localparam logic CSR_INTEG_GAIN  = 1'b1;

   localparam logic [31:0] ARCTAN [24] = '{
      32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
      32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051};

   // first member sits in the top bits, so the list runs from the highest field down
   typedef struct packed {
      logic signed [15:0] vehicle_surge;
      logic signed [31:0] vehicle_y;
      logic signed [31:0] vehicle_x;
      logic        [15:0] tan_len;
      logic signed [15:0] current_speed;
      logic signed [15:0] path_speed;
      logic signed [15:0] path_heading;
      logic signed [31:0] path_y;
      logic signed [31:0] path_x;
   } tick_type;

   typedef struct packed {
      logic        [6:0]  pad;
      logic signed [31:0] along_err;
      logic signed [31:0] lateral_err;
      logic signed [31:0] surge_cmd;
      logic signed [16:0] yaw_cmd;
   } command_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [207:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [119:0] rsp_tdata;
   logic         csr_we = 1'b0;
   logic         csr_addr = 1'b0;
   logic [15:0]  csr_wdata = '0;

   path_following_yaw_guidance DUT (.*);

   always #6 clock = ~clock;

   // model state
   logic [15:0] k_xtrack = '0;
   logic [15:0] k_integ  = '0;
   longint      xtrack_integral = 0;

   command_type pending_cmds[$];
   int          fail_count = 0;
   int          idle_cycles = 0;
   int          burst_left = 0;

   function automatic longint clip32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic command_type guidance_law(input tick_type t);
      command_type cmd;
      longint      ex, ey, x, y, z, xs, ys, t1, t2, mi, num, an, as_, mag, c;
      longint      rem, root, bit_, ang, yaw, imax, imin;
      logic [31:0] z32;
      ex = longint'(t.vehicle_x) - longint'(t.path_x);
      ey = longint'(t.vehicle_y) - longint'(t.path_y);
      // rotate the error by minus the path heading
      z32 = 32'd0 - {t.path_heading, 16'h0000};
      if (z32 >= 32'h40000000 && z32 < 32'hC0000000) begin
         ex = -ex;
         ey = -ey;
         z32 = z32 + 32'h80000000;
      end
      z = longint'(signed'(z32));
      x = ex;
      y = ey;
      for (int i = 0; i < STEPS && i < 24; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x = x - ys; y = y + xs; z = z - longint'(ARCTAN[i]);
         end else begin
            x = x + ys; y = y - xs; z = z + longint'(ARCTAN[i]);
         end
      end
      ex = clip32((x * 10187982 + (64'sd1 <<< 23)) >>> 24);
      ey = clip32((y * 10187982 + (64'sd1 <<< 23)) >>> 24);

      imax = (64'sd1 <<< (INTEG_W - 1)) - 1;
      imin = -imax - 1;
      if (ey > 0 && xtrack_integral > imax - ey) xtrack_integral = imax;
      else if (ey < 0 && xtrack_integral < imin - ey) xtrack_integral = imin;
      else xtrack_integral = xtrack_integral + ey;

      t1 = longint'(k_xtrack) * ey;
      mi = (xtrack_integral < 0) ? -xtrack_integral : xtrack_integral;
      if (mi > (64'sd1 <<< 48)) mi = 64'sd1 <<< 48;
      t2 = longint'(k_integ) * mi;
      if (t2 > (64'sd1 <<< 50)) t2 = 64'sd1 <<< 50;
      if (xtrack_integral < 0) t2 = -t2;
      num = t1 + t2;

      if (num == 0) begin
         c = 0;
      end else begin
         an  = (num < 0) ? -num : num;
         as_ = (t.vehicle_surge < 0) ? -longint'(t.vehicle_surge) : longint'(t.vehicle_surge);
         if (an >= (as_ <<< 16)) mag = 64'sd1 <<< 30;
         else mag = (an <<< 14) / as_;
         c = ((num < 0) != (t.vehicle_surge < 0)) ? mag : -mag;
      end

      // floor square root of 1 - c*c in Q30
      mag  = (c < 0) ? -c : c;
      rem  = (64'sd1 <<< 60) - mag * mag;
      root = 0;
      bit_ = 64'sd1 <<< 62;
      while (bit_ > rem) bit_ = bit_ >>> 2;
      while (bit_ != 0) begin
         if (rem >= root + bit_) begin
            rem  = rem - (root + bit_);
            root = (root >>> 1) + bit_;
         end else begin
            root = root >>> 1;
         end
         bit_ = bit_ >>> 2;
      end

      // arcsine by vectoring
      x = root;
      y = c;
      ang = 0;
      for (int i = 0; i < STEPS && i < 24; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y < 0) begin
            x = x - ys; y = y + xs; ang = ang - longint'(ARCTAN[i]);
         end else begin
            x = x + ys; y = y - xs; ang = ang + longint'(ARCTAN[i]);
         end
      end
      yaw = ((longint'(t.path_heading) * 65536 + ang) * 46080 + (64'sd1 <<< 31)) >>> 32;

      cmd.pad         = '0;
      cmd.yaw_cmd     = yaw[16:0];
      cmd.surge_cmd   = clip32((longint'(t.path_speed) + longint'(t.current_speed))
                               * longint'(t.tan_len));
      cmd.lateral_err = ey[31:0];
      cmd.along_err   = ex[31:0];
      return cmd;
   endfunction

   task automatic send_tick(input tick_type t);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tdata  <= t;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      pending_cmds.push_back(guidance_law(t));
   endtask

   task automatic drain();
      while (pending_cmds.size() != 0) @(posedge clock);
   endtask

   task automatic write_gains(input logic [15:0] k1, input logic [15:0] k2);
      req_tvalid <= 1'b0;
      drain();
      // let a clamped or zero-numerator item drain fully
      repeat (150) @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_XTRACK_GAIN;
      csr_wdata <= k1;
      @(posedge clock);
      csr_addr  <= CSR_INTEG_GAIN;
      csr_wdata <= k2;
      @(posedge clock);
      csr_we    <= 1'b0;
      k_xtrack = k1;
      k_integ  = k2;
   endtask

   function automatic tick_type random_tick();
      tick_type t;
      t = 208'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      if ($urandom_range(0, 9) >= 3) begin
         // vehicle close to the path so the correction is not always clamped
         t.vehicle_x = t.path_x + signed'(32'($urandom_range(0, 2097152))) - 32'sd1048576;
         t.vehicle_y = t.path_y + signed'(32'($urandom_range(0, 2097152))) - 32'sd1048576;
         t.path_speed    = signed'(16'($urandom_range(0, 2047))) - 16'sd1024;
         t.current_speed = signed'(16'($urandom_range(0, 255))) - 16'sd128;
         t.tan_len       = 16'($urandom_range(0, 1023));
         case ($urandom_range(0, 3))
            0: t.vehicle_surge = '0;
            1: t.vehicle_surge = signed'(16'($urandom_range(0, 1023))) - 16'sd512;
            default: ;
         endcase
      end
      return t;
   endfunction

   task automatic run_random(input int n);
      repeat (n) send_tick(random_tick());
   endtask

   task automatic test_directed();
      tick_type           t;
      logic signed [15:0] headings[5] = '{16'sd0, 16'sd16384, -16'sd32768, 16'sd32767,
                                          -16'sd16384};
      write_gains(16'h0100, 16'h0001);
      send_tick('0);
      t = '1;
      t.vehicle_x = 32'sh7FFFFFFF; t.vehicle_y = 32'sh7FFFFFFF;
      t.path_x = 32'sh80000000; t.path_y = 32'sh80000000;
      t.path_speed = 16'sh7FFF; t.current_speed = 16'sh7FFF; t.tan_len = 16'hFFFF;
      send_tick(t);                               // error and surge saturation
      t.path_x = 32'sh7FFFFFFF; t.path_y = 32'sh7FFFFFFF;
      t.vehicle_x = 32'sh80000000; t.vehicle_y = 32'sh80000000;
      t.path_speed = 16'sh8000; t.current_speed = 16'sh8000;
      send_tick(t);
      foreach (headings[i]) begin
         t = '0;
         t.vehicle_x = 32'sh00030000; t.vehicle_y = 32'sh00010000;
         t.path_heading = headings[i];
         t.vehicle_surge = 16'sh0100;
         t.path_speed = 16'sh0200; t.tan_len = 16'h0100;
         send_tick(t);
      end
      // zero surge with both signs of lateral error
      t = '0; t.vehicle_y = 32'sh00020000; send_tick(t);
      t.vehicle_y = -32'sh00080000; send_tick(t);
      // large correction against small positive and full-scale negative surge, then small error
      t.vehicle_y = 32'sh00400000; t.vehicle_surge = 16'sh0001; send_tick(t);
      t.vehicle_surge = 16'sh8000; send_tick(t);
      t.vehicle_surge = 16'sh7FFF; t.vehicle_y = 32'sh00000100; send_tick(t);
      // gains at zero give a zero numerator
      write_gains(16'h0000, 16'h0000);
      t.vehicle_y = 32'sh00400000; t.vehicle_surge = 16'sh0000; send_tick(t);
      t.vehicle_surge = 16'sh0123; send_tick(t);
   endtask

   task automatic test_gain_sweep();
      write_gains(16'h0000, 16'h0000);  run_random(150);
      write_gains(16'hFFFF, 16'hFFFF);  run_random(250);
      write_gains(16'h0100, 16'h0010);  run_random(400);
      repeat (3) begin
         write_gains(16'($urandom), 16'($urandom_range(0, 255)));
         run_random(250);
      end
   endtask

   // receiver stall pattern: phases of always-ready, random and long stalls
   int stall_mode = 0;
   int stall_left = 0;
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = $urandom_range(20, 400);
      end
      stall_left--;
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= $urandom_range(0, 1);
         default: rsp_tready <= ($urandom_range(0, 15) == 0);
      endcase
   end

   always @(posedge clock) begin
      command_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_cmds.size() == 0) begin
            $error("unexpected result beat %h", rsp_tdata);
            fail_count++;
         end else begin
            want = pending_cmds.pop_front();
            if (got.yaw_cmd !== want.yaw_cmd) begin
               $error("desired_yaw exp %0d got %0d", want.yaw_cmd, got.yaw_cmd);
               fail_count++;
            end
            if (got.surge_cmd !== want.surge_cmd) begin
               $error("desired_surge exp %0d got %0d", want.surge_cmd, got.surge_cmd);
               fail_count++;
            end
            if (got.lateral_err !== want.lateral_err) begin
               $error("lateral_err exp %0d got %0d", want.lateral_err,
                      got.lateral_err);
               fail_count++;
            end
            if (got.along_err !== want.along_err) begin
               $error("along_err exp %0d got %0d", want.along_err,
                      got.along_err);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles with no beat moving on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WDOG_MAX) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_gain_sweep();
      req_tvalid <= 1'b0;
      drain();
      repeat (150) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

[sim.f]
src/pfyg_pkg.sv
src/pfyg_cordic.sv
src/pfyg_shiftsub.sv
src/path_following_yaw_guidance.sv
tb/path_following_yaw_guidance_tb.sv
